>>> rtl/bre_pkg.sv
`timescale 1ns / 1ps

package bre_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);

  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned LUMA_R     = 306;
  localparam int unsigned LUMA_G     = 601;
  localparam int unsigned LUMA_B     = 117;
  localparam int unsigned LUMA_SHIFT = 10;
  localparam int unsigned LUMA_SUM_W = 18;
  localparam logic [7:0]  MONO_THRESH = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH    = 1'b0,
    REG_PIXEL_FORMAT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_BGR24  = 2'd0,
    FMT_MONO1  = 2'd1,
    FMT_LUMA8  = 2'd2,
    FMT_GREEN8 = 2'd3
  } pixel_format_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_done;
    logic       run_last;
  } row_byte_t;

endpackage

>>> rtl/bmp_row_encoder.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake            | Payload
// pixel    | in  | in_valid_i/in_stall_o  | bre_pkg::pixel_t (red, green, blue)
// row byte | out | out_valid_o/out_stall_i| bre_pkg::row_byte_t (out_byte, row_done, run_last)
// config   | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A pixel passes an input register, then is expanded into a byte burst register
// (up to three data bytes plus up to three pad bytes) that drains one byte per cycle,
// while the output is not stalled, into the output register. A pixel gives 3 data
// bytes for BGR, 1 for luma/green, and in one-bit mode one byte per eight pixels or
// at row end, plus the pad bytes at row end. The input register can take the next
// pixel while the burst drains; its first byte leaves through the output register.
// Reset returns row_width to 1, format to BGR and clears row position.
// Output stall holds the byte; the input register still takes one more pixel.
module bmp_row_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bre_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bre_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bre_pkg::pixel_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bre_pkg::row_byte_t                 out_data_o
);

  localparam int unsigned CW = bre_pkg::COL_W;

  // configuration
  logic [bre_pkg::ROW_WIDTH_W-1:0] row_width_q;
  bre_pkg::pixel_format_e          fmt_q;

  // row state
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    acc_q, acc_d;
  logic [2:0]    bits_q, bits_d;
  logic [1:0]    cnt_q, cnt_d;   // bytes emitted in the row, mod 4

  // input register
  logic            in_vld_q;
  bre_pkg::pixel_t pix_q;

  // byte burst register
  logic            bst_vld_q;
  logic [2:0][7:0] bst_byte_q, bst_byte_d;
  logic [1:0]      bst_ndata_q, ndata;
  logic [2:0]      bst_total_q, total;
  logic            bst_row_q;
  logic [2:0]      bst_idx_q;

  // output register
  logic               out_vld_q;
  bre_pkg::row_byte_t out_q, out_d;

  logic          in_acc, move, emit, bst_last, bst_free;
  logic [CW:0]   width_eff;
  logic          last;
  logic          mono_bit;
  logic [3:0]    held;
  logic [7:0]    acc_next, mono_byte;
  logic [bre_pkg::LUMA_SUM_W-1:0] luma_sum;
  logic [1:0]    cnt_sum, pad;

  always_comb begin
    if (row_width_q == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(row_width_q) > bre_pkg::MAX_WIDTH) begin
      width_eff = (CW+1)'(bre_pkg::MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(row_width_q);
    end
  end

  assign last = ({1'b0, col_q} + (CW+1)'(1)) >= width_eff;

  assign mono_bit  = (pix_q.red > bre_pkg::MONO_THRESH) && (pix_q.green > bre_pkg::MONO_THRESH)
                     && (pix_q.blue > bre_pkg::MONO_THRESH);
  assign held      = {1'b0, bits_q} + 4'd1;
  assign acc_next  = {acc_q[6:0], mono_bit};
  assign mono_byte = acc_next << (4'd8 - held);

  assign luma_sum = bre_pkg::LUMA_SUM_W'(pix_q.red)   * bre_pkg::LUMA_SUM_W'(bre_pkg::LUMA_R)
                  + bre_pkg::LUMA_SUM_W'(pix_q.green) * bre_pkg::LUMA_SUM_W'(bre_pkg::LUMA_G)
                  + bre_pkg::LUMA_SUM_W'(pix_q.blue)  * bre_pkg::LUMA_SUM_W'(bre_pkg::LUMA_B);

  // expand the held pixel into its byte burst and the next row state
  always_comb begin
    bst_byte_d = '0;
    ndata      = 2'd1;
    acc_d      = acc_q;
    bits_d     = bits_q;
    case (fmt_q)
      bre_pkg::FMT_BGR24: begin
        bst_byte_d[0] = pix_q.blue;
        bst_byte_d[1] = pix_q.green;
        bst_byte_d[2] = pix_q.red;
        ndata         = 2'd3;
      end
      bre_pkg::FMT_MONO1: begin
        if (held == 4'd8 || last) begin
          bst_byte_d[0] = mono_byte;
          acc_d         = '0;
          bits_d        = '0;
        end else begin
          ndata  = 2'd0;
          acc_d  = acc_next;
          bits_d = held[2:0];
        end
      end
      bre_pkg::FMT_LUMA8: begin
        bst_byte_d[0] = 8'(luma_sum >> bre_pkg::LUMA_SHIFT);
      end
      default: begin
        bst_byte_d[0] = pix_q.green;
      end
    endcase

    cnt_sum = cnt_q + ndata;
    if (last) begin
      pad    = 2'(3'd4 - {1'b0, cnt_sum});
      col_d  = '0;
      cnt_d  = '0;
      acc_d  = '0;
      bits_d = '0;
    end else begin
      pad   = 2'd0;
      col_d = col_q + CW'(1);
      cnt_d = cnt_sum;
    end
    total = {1'b0, ndata} + {1'b0, pad};
  end

  // handshake between stages
  assign emit     = bst_vld_q && (!out_vld_q || !out_stall_i);
  assign bst_last = bst_idx_q == (bst_total_q - 3'd1);
  assign bst_free = !bst_vld_q || (emit && bst_last);
  assign move     = in_vld_q && bst_free;
  assign in_stall_o = in_vld_q && !move;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    out_d.out_byte = (bst_idx_q < {1'b0, bst_ndata_q}) ? bst_byte_q[bst_idx_q[1:0]] : 8'd0;
    out_d.row_done = bst_row_q && bst_last;
    out_d.run_last = bst_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= bre_pkg::ROW_WIDTH_W'(1);
      fmt_q       <= bre_pkg::FMT_BGR24;
      col_q       <= '0;
      acc_q       <= '0;
      bits_q      <= '0;
      cnt_q       <= '0;
    end else if (cfg_we_i) begin
      case (bre_pkg::cfg_reg_e'(cfg_idx_i))
        bre_pkg::REG_ROW_WIDTH:    row_width_q <= cfg_data_i;
        bre_pkg::REG_PIXEL_FORMAT: fmt_q <= bre_pkg::pixel_format_e'(cfg_data_i[1:0]);
        default: ;
      endcase
      // any write abandons the row in progress
      col_q  <= '0;
      acc_q  <= '0;
      bits_q <= '0;
      cnt_q  <= '0;
    end else if (move) begin
      col_q  <= col_d;
      acc_q  <= acc_d;
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      bst_vld_q <= 1'b0;
      bst_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end

      if (move) begin
        bst_vld_q <= total != 3'd0;
        bst_idx_q <= '0;
      end else if (emit) begin
        if (bst_last) begin
          bst_vld_q <= 1'b0;
        end
        bst_idx_q <= bst_idx_q + 3'd1;
      end

      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= in_data_i;
    end
    if (move) begin
      bst_byte_q  <= bst_byte_d;
      bst_ndata_q <= ndata;
      bst_total_q <= total;
      bst_row_q   <= last;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/bre_checker.sv
`timescale 1ns / 1ps

module bre_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input bre_pkg::row_byte_t             out_data_o
);

  // a held byte stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output request changed while stalled");

  // end of row is always the last byte of that pixel's burst
  a_row_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.row_done |-> out_data_o.run_last)
    else $error("row_done without run_last");

  // bytes of one pixel come without gaps
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside a pixel burst");

  // no stall with nothing pending inside
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!in_valid_i || in_stall_o) && $past(!out_valid_o) && $past(!in_stall_o)
    |-> !in_stall_o)
    else $error("input stalled while empty");

endmodule

bind bmp_row_encoder bre_checker u_bre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
